// File: hdl/http_response_head_parser_core_assert.svh
// Assertion macros for the HTTP response head parser core.
`ifndef HTTP_RESPONSE_HEAD_PARSER_CORE_ASSERT_SVH
`define HTTP_RESPONSE_HEAD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HRHP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HRHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hrhp_pkg.sv
// Shared types, codes and constants of the HTTP response head parser.
`default_nettype none

package hrhp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int BODY_LEN_W      = 32;
    localparam int KEY_LEN         = 14;
    localparam int RESULT_BITS     = 2 + 8 + 1 + BODY_LEN_W;
    localparam int OUT_TDATA_W     = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        PS_H, PS_T1, PS_T2, PS_P, PS_SLASH, PS_MAJOR, PS_DOT, PS_MINOR,
        PS_VEREND, PS_CODE, PS_REASON, PS_LF, PS_NAME, PS_VALUE, PS_ENDLF, PS_BODY
    } t_parse_state;

    typedef enum logic [1:0] {
        STATUS_BUSY    = 2'd0,
        STATUS_DONE    = 2'd1,
        STATUS_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_FRAMING, KIND_MAJOR, KIND_MINOR, KIND_CODE,
        KIND_REASON, KIND_NAME, KIND_VALUE, KIND_BODY
    } t_kind;

    localparam logic [7:0] CHR_H     = 8'h48;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_P     = 8'h50;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        t_kind                 kind;
        logic [7:0]            data;
        logic                  field_end;
        logic [BODY_LEN_W-1:0] body_length;
        logic                  last_body_byte;
    } t_result;

    // Characters of the header name Content-Length, by match position.
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hrhp_in_reg.sv
// Input register stage: holds one accepted byte transaction for the parser.
`default_nettype none

module hrhp_in_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic               i_take,
    input  wire hrhp_pkg::t_in_item i_item,
    output logic                    o_valid,
    output hrhp_pkg::t_in_item      o_item
);
    import hrhp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: hdl/hrhp_parse.sv
// Parser state machine, header name match and content length accumulator.
`default_nettype none

module hrhp_parse #(
    parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire hrhp_pkg::t_in_item i_item,
    output hrhp_pkg::t_result       o_result
);
    import hrhp_pkg::*;

    t_parse_state           r_state, n_state;
    logic [3:0]             r_nm_pos, n_nm_pos;
    logic                   r_nm_ok, n_nm_ok;
    logic                   r_nm_started, n_nm_started;
    logic                   r_nm_trail, n_nm_trail;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_vd_started, n_vd_started;
    logic                   r_vd_trail, n_vd_trail;
    logic                   r_vd_bad, n_vd_bad;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;

    logic [7:0]                        w_b;
    logic                              w_ok;
    logic                              w_key_hit;
    logic                              w_dig09;
    logic                              w_dig19;
    logic [LENGTH_BITS+3:0]            w_len_full;
    logic                              w_len_ovf;
    logic [LENGTH_BITS-1:0]            w_rem_dec;
    logic                              w_body_end;
    logic [LENGTH_BITS+BODY_LEN_W-1:0] w_len_ext;
    t_result                           w_res;

    assign w_b       = i_item.data;
    assign w_key_hit = r_nm_ok && (r_nm_pos == 4'(KEY_LEN));
    assign w_dig09   = (w_b >= CHR_ZERO) && (w_b <= CHR_NINE);
    assign w_dig19   = (w_b >= CHR_ONE) && (w_b <= CHR_NINE);

    // length * 10 + digit, with four guard bits to catch overflow
    assign w_len_full = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0}
                      + {{LENGTH_BITS{1'b0}}, w_b[3:0]};
    assign w_len_ovf  = |w_len_full[LENGTH_BITS+3:LENGTH_BITS];

    assign w_rem_dec  = (r_rem != '0) ? (r_rem - LENGTH_BITS'(1)) : r_rem;
    assign w_body_end = (w_rem_dec == '0);

    // Decide whether the byte is legal in the current state.
    always_comb begin
        unique case (r_state)
            PS_H:      w_ok = (w_b == CHR_H);
            PS_T1:     w_ok = (w_b == CHR_T);
            PS_T2:     w_ok = (w_b == CHR_T);
            PS_P:      w_ok = (w_b == CHR_P);
            PS_SLASH:  w_ok = (w_b == CHR_SLASH);
            PS_MAJOR:  w_ok = w_dig19;
            PS_DOT:    w_ok = (w_b == CHR_DOT);
            PS_MINOR:  w_ok = w_dig09;
            PS_VEREND: w_ok = (w_b == CHR_SPACE);
            PS_CODE:   w_ok = (w_b >= CHR_SPACE);
            PS_REASON: w_ok = (w_b == CHR_CR) || (w_b >= CHR_SPACE);
            PS_LF:     w_ok = (w_b == CHR_LF);
            PS_NAME:   w_ok = (w_b == CHR_CR) || (w_b >= CHR_SPACE);
            PS_VALUE:  w_ok = (w_b == CHR_CR) || (w_b >= CHR_SPACE);
            PS_ENDLF:  w_ok = (w_b == CHR_LF) && !r_vd_bad;
            PS_BODY:   w_ok = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (i_item.restart) begin
            n_state = PS_H;
        end else if (w_ok) begin
            unique case (r_state)
                PS_H:      n_state = PS_T1;
                PS_T1:     n_state = PS_T2;
                PS_T2:     n_state = PS_P;
                PS_P:      n_state = PS_SLASH;
                PS_SLASH:  n_state = PS_MAJOR;
                PS_MAJOR:  n_state = PS_DOT;
                PS_DOT:    n_state = PS_MINOR;
                PS_MINOR:  n_state = PS_VEREND;
                PS_VEREND: n_state = PS_CODE;
                PS_CODE:   n_state = (w_b == CHR_SPACE) ? PS_REASON : PS_CODE;
                PS_REASON: n_state = (w_b == CHR_CR) ? PS_LF : PS_REASON;
                PS_LF:     n_state = PS_NAME;
                PS_NAME: begin
                    if (w_b == CHR_COLON) begin
                        n_state = PS_VALUE;
                    end else if (w_b == CHR_CR) begin
                        n_state = PS_ENDLF;
                    end
                end
                PS_VALUE:  n_state = (w_b == CHR_CR) ? PS_LF : PS_VALUE;
                PS_ENDLF:  n_state = (r_len == '0) ? PS_H : PS_BODY;
                PS_BODY:   n_state = w_body_end ? PS_H : PS_BODY;
            endcase
        end
    end

    // Result of the byte.
    always_comb begin
        w_res                = '0;
        w_res.status         = STATUS_BUSY;
        w_res.kind           = KIND_FRAMING;
        w_res.data           = w_b;
        w_res.body_length    = w_len_ext[BODY_LEN_W-1:0];
        if (i_item.restart) begin
            w_res.data = 8'h00;
        end else if (!w_ok) begin
            w_res.status = STATUS_INVALID;
        end else begin
            unique case (r_state)
                PS_MAJOR: begin
                    w_res.kind = KIND_MAJOR;
                    w_res.data = {4'h0, w_b[3:0]};
                end
                PS_MINOR: begin
                    w_res.kind = KIND_MINOR;
                    w_res.data = {4'h0, w_b[3:0]};
                end
                PS_CODE: begin
                    if (w_b == CHR_SPACE) begin
                        w_res.field_end = 1'b1;
                    end else begin
                        w_res.kind = KIND_CODE;
                    end
                end
                PS_REASON: begin
                    if (w_b == CHR_CR) begin
                        w_res.field_end = 1'b1;
                    end else begin
                        w_res.kind = KIND_REASON;
                    end
                end
                PS_NAME: begin
                    if ((w_b != CHR_COLON) && (w_b != CHR_CR)) begin
                        w_res.kind = KIND_NAME;
                    end
                end
                PS_VALUE: begin
                    if (w_b == CHR_CR) begin
                        w_res.field_end = 1'b1;
                    end else begin
                        w_res.kind = KIND_VALUE;
                    end
                end
                PS_ENDLF: begin
                    if (r_len == '0) begin
                        w_res.status = STATUS_DONE;
                    end
                end
                PS_BODY: begin
                    w_res.kind = KIND_BODY;
                    if (w_body_end) begin
                        w_res.status         = STATUS_DONE;
                        w_res.last_body_byte = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Name match, length value and body count.
    always_comb begin
        n_nm_pos     = r_nm_pos;
        n_nm_ok      = r_nm_ok;
        n_nm_started = r_nm_started;
        n_nm_trail   = r_nm_trail;
        n_len        = r_len;
        n_vd_started = r_vd_started;
        n_vd_trail   = r_vd_trail;
        n_vd_bad     = r_vd_bad;
        n_rem        = r_rem;
        if (i_item.restart) begin
            n_nm_pos     = 4'h0;
            n_nm_ok      = 1'b0;
            n_nm_started = 1'b0;
            n_nm_trail   = 1'b0;
            n_len        = '0;
            n_vd_started = 1'b0;
            n_vd_trail   = 1'b0;
            n_vd_bad     = 1'b0;
            n_rem        = '0;
        end else if (w_ok) begin
            case (r_state)
                PS_H: begin
                    n_len        = '0;
                    n_vd_started = 1'b0;
                    n_vd_trail   = 1'b0;
                    n_vd_bad     = 1'b0;
                end
                PS_LF: begin
                    n_nm_pos     = 4'h0;
                    n_nm_ok      = 1'b1;
                    n_nm_started = 1'b0;
                    n_nm_trail   = 1'b0;
                end
                PS_NAME: begin
                    if (w_b == CHR_COLON) begin
                        if (w_key_hit) begin
                            n_len        = '0;
                            n_vd_started = 1'b0;
                            n_vd_trail   = 1'b0;
                            n_vd_bad     = 1'b0;
                        end
                    end else if (w_b == CHR_CR) begin
                        // drop the partial name
                    end else if (w_b == CHR_SPACE) begin
                        if (r_nm_started) begin
                            n_nm_trail = 1'b1;
                        end
                    end else if (r_nm_trail) begin
                        n_nm_ok = 1'b0;
                    end else begin
                        n_nm_started = 1'b1;
                        if (r_nm_ok) begin
                            if ((r_nm_pos < 4'(KEY_LEN)) && (key_char(r_nm_pos) == w_b)) begin
                                n_nm_pos = r_nm_pos + 4'h1;
                            end else begin
                                n_nm_ok = 1'b0;
                            end
                        end
                    end
                end
                PS_VALUE: begin
                    if ((w_b != CHR_CR) && w_key_hit) begin
                        if (w_b == CHR_SPACE) begin
                            if (r_vd_started) begin
                                n_vd_trail = 1'b1;
                            end
                        end else if (!w_dig09 || r_vd_trail || r_vd_bad) begin
                            n_vd_bad = 1'b1;
                        end else begin
                            n_vd_started = 1'b1;
                            if (w_len_ovf) begin
                                n_vd_bad = 1'b1;
                            end else begin
                                n_len = w_len_full[LENGTH_BITS-1:0];
                            end
                        end
                    end
                end
                PS_ENDLF: begin
                    if (r_len != '0) begin
                        n_rem = r_len;
                    end
                end
                PS_BODY: begin
                    n_rem = w_rem_dec;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_len_ext = {{BODY_LEN_W{1'b0}}, n_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= PS_H;
            r_nm_pos     <= 4'h0;
            r_nm_ok      <= 1'b0;
            r_nm_started <= 1'b0;
            r_nm_trail   <= 1'b0;
            r_len        <= '0;
            r_vd_started <= 1'b0;
            r_vd_trail   <= 1'b0;
            r_vd_bad     <= 1'b0;
            r_rem        <= '0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_nm_pos     <= n_nm_pos;
            r_nm_ok      <= n_nm_ok;
            r_nm_started <= n_nm_started;
            r_nm_trail   <= n_nm_trail;
            r_len        <= n_len;
            r_vd_started <= n_vd_started;
            r_vd_trail   <= n_vd_trail;
            r_vd_bad     <= n_vd_bad;
            r_rem        <= n_rem;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

// File: hdl/hrhp_out_reg.sv
// Result register stage: holds one tagged byte until the sink takes it.
`default_nettype none

module hrhp_out_reg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic                           i_ready,
    input  wire hrhp_pkg::t_result              i_result,
    output logic                                o_valid,
    output logic [hrhp_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic [2:0]                          o_tuser,
    output logic                                o_tlast
);
    import hrhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = {{(OUT_TDATA_W-RESULT_BITS){1'b0}}, r_result.body_length,
                      r_result.field_end, r_result.data, r_result.status};
    assign o_tuser = r_result.kind;
    assign o_tlast = r_result.last_body_byte;

endmodule

`default_nettype wire

// File: hdl/http_response_head_parser_core.sv
// Top level of the HTTP response head parser: byte stream in, tagged bytes out.
//
// Usage
//   Slave stream: one response byte per transaction in s_axis_tdata; s_axis_tuser
//   set to 1 restarts the parser (the byte is ignored, a framing result is
//   still produced). Every input transaction yields exactly one result.
//   Master stream: m_axis_tdata carries status, byte or digit value, field end
//   and the parsed content length; m_axis_tuser tags the byte role; m_axis_tlast
//   marks the final body byte of a message.
//   The input register takes the byte, and the state machine then writes the result
//   register once the result register is free or being drained.
//   Throughput: one byte per cycle while the sink does not stall.
//   When the sink stalls, the result register holds and the input register
//   still takes one more byte; after that s_axis_tready drops until the sink
//   takes the result.
//   An invalid byte is reported with status invalid and leaves the parser
//   where it was; a later legal byte, a restart transaction or reset moves it on.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to the start of a response, expecting the H of the status line.
`default_nettype none

module http_response_head_parser_core #(
    parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] byte_in
    input  wire logic [0:0]                        s_axis_tuser,  // [0] restart
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] status, [9:2] data_out, [10] field_end, [42:11] body_length, rest zero
    output logic [hrhp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic [2:0]                             m_axis_tuser,  // [2:0] kind
    output logic                                   m_axis_tlast   // last_body_byte
);
    import hrhp_pkg::*;

    logic     w_in_accept;
    logic     w_in_valid;
    logic     w_advance;
    logic     w_step;
    t_in_item w_in_item;
    t_in_item w_held_item;
    t_result  w_result;

    // Advance whenever the result register is free or being drained.
    assign w_advance     = !m_axis_tvalid || m_axis_tready;
    assign w_step        = w_in_valid && w_advance;
    assign s_axis_tready = !w_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    assign w_in_item.data    = s_axis_tdata;
    assign w_in_item.restart = s_axis_tuser[0];

    hrhp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_accept),
        .i_take  (w_step),
        .i_item  (w_in_item),
        .o_valid (w_in_valid),
        .o_item  (w_held_item)
    );

    // Update the parse state and form the result in the same cycle.
    hrhp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_held_item),
        .o_result (w_result)
    );

    hrhp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_ready  (m_axis_tready),
        .i_result (w_result),
        .o_valid  (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

`include "http_response_head_parser_core_assert.svh"

    // The final body byte always completes the message as a body byte.
    `HRHP_ASSERT_SAME(a_last_is_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
        (m_axis_tdata[1:0] == STATUS_DONE) && (m_axis_tuser == KIND_BODY),
        "last body byte without completion")

    // An invalid byte is a framing result with no field end and no last flag.
    `HRHP_ASSERT_SAME(a_invalid_clean, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[1:0] == STATUS_INVALID),
        (m_axis_tuser == KIND_FRAMING) && !m_axis_tdata[10] && !m_axis_tlast,
        "invalid result carries role flags")

    // A field end is a framing byte of an unfinished message.
    `HRHP_ASSERT_SAME(a_fend_framing, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[10],
        (m_axis_tuser == KIND_FRAMING) && (m_axis_tdata[1:0] == STATUS_BUSY),
        "field end on a non-framing byte")

    // A held input byte waits in the input register while the result stalls.
    `HRHP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, w_in_valid && !w_advance,
        w_in_valid, "held input byte lost during stall")

endmodule

`default_nettype wire

// File: bench/tb_http_response_head_parser_core.sv
// Testbench of the HTTP response head parser core: byte streams checked against a predictor.
module tb_http_response_head_parser_core;
    import hrhp_pkg::*;

    localparam int GAP_MAX      = 13;
    localparam int SINK_HOLD    = 90;      // long receiver hold-off, in cycles
    localparam int HOLD_AT      = 120;     // result count at which the hold-off starts
    localparam int ITEM_TARGET  = 420;
    localparam int QUIET_LIMIT  = 1000;    // cycles without any transaction
    localparam int DRAIN_CYCLES = 6;
    localparam int REPORT_MAX   = 10;
    localparam int SHORT_BODY   = 48;      // longer bodies are cut short and restarted
    localparam logic [BODY_LEN_W-1:0] LEN_MAX = '1;
    localparam logic [8*KEY_LEN-1:0] LEN_HEADER = "Content-Length";

    localparam t_result RES_IDLE =
        '{STATUS_BUSY, KIND_FRAMING, 8'h00, 1'b0, 32'd0, 1'b0};

    typedef struct {
        logic [7:0] data;
        logic       restart;
        logic       pinned;     // result typed in below instead of predicted
        t_result    want;
    } t_head_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [7:0] byte_in
    logic [0:0]             s_axis_tuser = '0;   // [0] restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [1:0] status, [9:2] data, [10] field end,
                                                 // [42:11] body length
    logic [2:0]             m_axis_tuser;        // [2:0] kind
    logic                   m_axis_tlast;        // last body byte

    // Sideband that travels with the driven byte: a typed-in result for it.
    logic    pinned_valid = 1'b0;
    t_result pinned_want  = RES_IDLE;

    t_result   tagged_byte_q [$];
    t_in_item  resp_bytes [$];
    int        tag_errors = 0;
    int        sent = 0;
    int        src_calm = 0;
    int        quiet = 0;

    // Predicted parser state.
    t_parse_state           p_state;
    logic [3:0]             key_pos;
    logic                   key_ok, name_begun, name_trail;
    logic [BODY_LEN_W-1:0]  clen;
    logic                   val_begun, val_trail, val_bad;
    logic [BODY_LEN_W-1:0]  body_left;

    http_response_head_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_parser();
        p_state    = PS_H;
        key_pos    = '0;
        key_ok     = 1'b0;
        name_begun = 1'b0;
        name_trail = 1'b0;
        clen       = '0;
        val_begun  = 1'b0;
        val_trail  = 1'b0;
        val_bad    = 1'b0;
        body_left  = '0;
    endfunction

    // The current header name is exactly Content-Length, spaces trimmed.
    function automatic logic length_header();
        return key_ok && (key_pos == KEY_LEN);
    endfunction

    // Advance the predicted parser by one byte and return the tagged byte it gives.
    function automatic t_result tag_byte(input logic [7:0] b, input logic restart);
        t_result         r;
        logic            bad;
        longint unsigned grown;
        r   = '{STATUS_BUSY, KIND_FRAMING, b, 1'b0, 32'd0, 1'b0};
        bad = 1'b0;
        if (restart) begin
            clear_parser();
            r.data = 8'h00;
        end else begin
            case (p_state)
                PS_H: begin
                    if (b == CHR_H) begin
                        p_state   = PS_T1;
                        clen      = '0;
                        val_begun = 1'b0;
                        val_trail = 1'b0;
                        val_bad   = 1'b0;
                    end else bad = 1'b1;
                end
                PS_T1:    if (b == CHR_T) p_state = PS_T2; else bad = 1'b1;
                PS_T2:    if (b == CHR_T) p_state = PS_P; else bad = 1'b1;
                PS_P:     if (b == CHR_P) p_state = PS_SLASH; else bad = 1'b1;
                PS_SLASH: if (b == CHR_SLASH) p_state = PS_MAJOR; else bad = 1'b1;
                PS_MAJOR: begin
                    if (b >= CHR_ONE && b <= CHR_NINE) begin
                        r.kind  = KIND_MAJOR;
                        r.data  = b - CHR_ZERO;
                        p_state = PS_DOT;
                    end else bad = 1'b1;
                end
                PS_DOT:   if (b == CHR_DOT) p_state = PS_MINOR; else bad = 1'b1;
                PS_MINOR: begin
                    if (b >= CHR_ZERO && b <= CHR_NINE) begin
                        r.kind  = KIND_MINOR;
                        r.data  = b - CHR_ZERO;
                        p_state = PS_VEREND;
                    end else bad = 1'b1;
                end
                PS_VEREND: if (b == CHR_SPACE) p_state = PS_CODE; else bad = 1'b1;
                PS_CODE: begin
                    if (b == CHR_SPACE) begin
                        r.field_end = 1'b1;
                        p_state     = PS_REASON;
                    end else if (b > CHR_SPACE) r.kind = KIND_CODE;
                    else bad = 1'b1;
                end
                PS_REASON: begin
                    if (b == CHR_CR) begin
                        r.field_end = 1'b1;
                        p_state     = PS_LF;
                    end else if (b >= CHR_SPACE) r.kind = KIND_REASON;
                    else bad = 1'b1;
                end
                PS_LF: begin
                    if (b == CHR_LF) begin
                        p_state    = PS_NAME;
                        key_pos    = '0;
                        key_ok     = 1'b1;
                        name_begun = 1'b0;
                        name_trail = 1'b0;
                    end else bad = 1'b1;
                end
                PS_NAME: begin
                    if (b == CHR_COLON) begin
                        p_state = PS_VALUE;
                        // a counted header starts its value from scratch
                        if (length_header()) begin
                            clen      = '0;
                            val_begun = 1'b0;
                            val_trail = 1'b0;
                            val_bad   = 1'b0;
                        end
                    end else if (b == CHR_CR) begin
                        p_state = PS_ENDLF;     // drop the partial name, end the head
                    end else if (b >= CHR_SPACE) begin
                        r.kind = KIND_NAME;
                        if (b == CHR_SPACE) begin
                            if (name_begun) name_trail = 1'b1;
                        end else if (name_trail) begin
                            key_ok = 1'b0;      // text after a trailing space
                        end else begin
                            name_begun = 1'b1;
                            if (key_ok && key_pos < KEY_LEN &&
                                LEN_HEADER[8*(KEY_LEN-1-int'(key_pos)) +: 8] == b)
                                key_pos = key_pos + 4'd1;
                            else
                                key_ok = 1'b0;
                        end
                    end else bad = 1'b1;
                end
                PS_VALUE: begin
                    if (b == CHR_CR) begin
                        r.field_end = 1'b1;
                        p_state     = PS_LF;
                    end else if (b >= CHR_SPACE) begin
                        r.kind = KIND_VALUE;
                        if (length_header()) begin
                            if (b == CHR_SPACE) begin
                                if (val_begun) val_trail = 1'b1;
                            end else if (b < CHR_ZERO || b > CHR_NINE || val_trail || val_bad) begin
                                val_bad = 1'b1;
                            end else begin
                                val_begun = 1'b1;
                                grown = 64'(clen) * 64'd10 + 64'(b - CHR_ZERO);
                                if (grown > 64'(LEN_MAX)) val_bad = 1'b1;
                                else clen = grown[BODY_LEN_W-1:0];
                            end
                        end
                    end else bad = 1'b1;
                end
                PS_ENDLF: begin
                    if (b == CHR_LF && !val_bad) begin
                        if (clen == '0) begin
                            r.status = STATUS_DONE;
                            p_state  = PS_H;
                        end else begin
                            body_left = clen;
                            p_state   = PS_BODY;
                        end
                    end else bad = 1'b1;
                end
                default: begin
                    // body: count down, complete on the last byte
                    r.kind = KIND_BODY;
                    if (body_left != '0) body_left = body_left - 1'b1;
                    if (body_left == '0) begin
                        r.status         = STATUS_DONE;
                        r.last_body_byte = 1'b1;
                        p_state          = PS_H;
                    end
                end
            endcase
            if (bad) begin
                r.status         = STATUS_INVALID;
                r.kind           = KIND_FRAMING;
                r.field_end      = 1'b0;
                r.last_body_byte = 1'b0;
                r.data           = b;
            end
        end
        r.body_length = clen;
        return r;
    endfunction

    // Wait draw shared by both sides: mostly random, with runs of no waiting.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        resp_bytes.push_back('{data: b, restart: 1'b0});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    // Build one response into resp_bytes; clean says the parser ends at the start state.
    function automatic void build_response(output logic clean);
        logic [BODY_LEN_W-1:0] want_len;
        logic                  len_bad;
        int unsigned           v;
        int                    n_body;
        clean    = 1'b1;
        want_len = '0;
        len_bad  = 1'b0;
        resp_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise: random bytes with the odd restart among them
            repeat ($urandom_range(3, 12))
                resp_bytes.push_back('{data: 8'($urandom),
                                       restart: ($urandom_range(0, 7) == 0)});
            clean = 1'b0;
            return;
        end
        add_text("HTTP/");
        add_byte(8'($urandom_range(CHR_ONE, CHR_NINE)));
        add_byte(CHR_DOT);
        add_byte(8'($urandom_range(CHR_ZERO, CHR_NINE)));
        add_byte(CHR_SPACE);
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(8'h21, 8'hFF)));
        add_byte(CHR_SPACE);
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(CHR_SPACE, 8'hFF)));
        add_byte(CHR_CR);
        add_byte(CHR_LF);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 3))
                    0:       add_text("Content-Length");
                    1:       add_text(" Content-Length");
                    2:       add_text("Content-Length  ");
                    default: add_text("  Content-Length ");
                endcase
                add_byte(CHR_COLON);
                len_bad = 1'b0;
                case ($urandom_range(0, 11))
                    0: want_len = '0;
                    1: begin add_text("   "); want_len = '0; end
                    2, 3: begin add_text(" 4294967295"); want_len = LEN_MAX; end
                    4: begin add_text("4294967296"); len_bad = 1'b1; end
                    5: begin add_text("99999999999 "); len_bad = 1'b1; end
                    6: begin add_text("1 2"); len_bad = 1'b1; end
                    7: begin add_text("2a"); len_bad = 1'b1; end
                    8, 9: begin
                        v = $urandom();
                        add_text($sformatf("%0d", v));
                        want_len = v;
                    end
                    default: begin
                        v = $urandom_range(0, 12);
                        add_text($sformatf(" 00%0d ", v));
                        want_len = v;
                    end
                endcase
            end else begin
                // names that must not be counted
                case ($urandom_range(0, 4))
                    0: add_text("content-length");
                    1: add_text("Content-Len");
                    2: add_text("Content-Lengths");
                    3: add_text("Content -Length");
                    default: repeat ($urandom_range(0, 5))
                        add_byte(8'($urandom_range(8'h21, 8'hFF)));
                endcase
                add_byte(CHR_COLON);
                repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(CHR_SPACE, 8'hFF)));
            end
            add_byte(CHR_CR);
            add_byte(CHR_LF);
        end
        // end the head with a blank line, sometimes with a partial name cut by CR
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(8'h41, 8'h5A)));
        add_byte(CHR_CR);
        add_byte(CHR_LF);
        if (len_bad) begin
            // parser holds before the LF; offer it again once
            add_byte(CHR_LF);
            clean = 1'b0;
        end else if (want_len != '0) begin
            n_body = (want_len <= SHORT_BODY) ? int'(want_len) : $urandom_range(1, 8);
            repeat (n_body) add_byte(8'($urandom));
            if (want_len > SHORT_BODY) clean = 1'b0;
        end
        if ($urandom_range(0, 5) == 0) begin
            // break the message: overwrite a few bytes
            repeat ($urandom_range(1, 3))
                resp_bytes[$urandom_range(0, resp_bytes.size() - 1)].data = 8'($urandom);
            clean = 1'b0;
        end
    endfunction

    // Offer one byte after a random gap and hold it until the parser takes it.
    task automatic send_byte(input logic [7:0] b, input logic restart,
                             input logic pinned, input t_result want);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        pinned_valid  <= pinned;
        pinned_want   <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tagged_byte_q.size() != 0) @(posedge i_clk);
    endtask

    // Predict each accepted input transaction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            want = tag_byte(s_axis_tdata, s_axis_tuser[0]);
            if (pinned_valid) want = pinned_want;
            tagged_byte_q.push_back(want);
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tagged_byte_q.size() == 0) begin
                if (tag_errors < REPORT_MAX)
                    $display("unexpected result: status %0d kind %0d data %h",
                             m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[9:2]);
                tag_errors++;
            end else begin
                want = tagged_byte_q.pop_front();
                if (m_axis_tdata[1:0] !== want.status || m_axis_tuser !== want.kind ||
                    m_axis_tdata[9:2] !== want.data || m_axis_tdata[10] !== want.field_end ||
                    m_axis_tdata[11 +: BODY_LEN_W] !== want.body_length ||
                    m_axis_tlast !== want.last_body_byte) begin
                    if (tag_errors < REPORT_MAX)
                        $display({"mismatch: expected st %0d kind %0d data %h end %b len %0d",
                                  " last %b, got st %0d kind %0d data %h end %b len %0d last %b"},
                                 want.status, want.kind, want.data, want.field_end,
                                 want.body_length, want.last_body_byte,
                                 m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[9:2],
                                 m_axis_tdata[10], m_axis_tdata[11 +: BODY_LEN_W], m_axis_tlast);
                    tag_errors++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off while the sender keeps offering.
    initial begin
        int stall;
        int taken;
        int sink_calm;
        taken     = 0;
        sink_calm = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = (taken == HOLD_AT) ? SINK_HOLD : draw_wait(sink_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sender: directed rows, then random responses.
    initial begin
        t_head_row rows [0:23];
        logic      clean;
        logic      paused;
        clear_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{8'hA5,     1'b1, 1'b1, RES_IDLE},     // restart ignores the byte
            '{8'h00,     1'b0, 1'b1, '{STATUS_INVALID, KIND_FRAMING, 8'h00, 1'b0, 32'd0, 1'b0}},
            '{8'hFF,     1'b0, 1'b1, '{STATUS_INVALID, KIND_FRAMING, 8'hFF, 1'b0, 32'd0, 1'b0}},
            '{CHR_H,     1'b0, 1'b0, RES_IDLE},
            '{CHR_T,     1'b0, 1'b0, RES_IDLE},
            '{CHR_T,     1'b0, 1'b0, RES_IDLE},
            '{CHR_P,     1'b0, 1'b0, RES_IDLE},
            '{CHR_SLASH, 1'b0, 1'b0, RES_IDLE},
            // major digit zero is refused, nine taken
            '{CHR_ZERO,  1'b0, 1'b1, '{STATUS_INVALID, KIND_FRAMING, CHR_ZERO, 1'b0, 32'd0, 1'b0}},
            '{CHR_NINE,  1'b0, 1'b1, '{STATUS_BUSY, KIND_MAJOR, 8'd9, 1'b0, 32'd0, 1'b0}},
            '{CHR_DOT,   1'b0, 1'b0, RES_IDLE},
            '{CHR_ZERO,  1'b0, 1'b1, '{STATUS_BUSY, KIND_MINOR, 8'd0, 1'b0, 32'd0, 1'b0}},
            '{CHR_SPACE, 1'b0, 1'b0, RES_IDLE},
            '{8'hFF,     1'b0, 1'b0, RES_IDLE},     // high byte in the code
            '{8'h21,     1'b0, 1'b0, RES_IDLE},
            '{CHR_SPACE, 1'b0, 1'b0, RES_IDLE},
            '{8'h80,     1'b0, 1'b0, RES_IDLE},     // high byte in the reason
            '{8'h1F,     1'b0, 1'b1, '{STATUS_INVALID, KIND_FRAMING, 8'h1F, 1'b0, 32'd0, 1'b0}},
            '{CHR_CR,    1'b0, 1'b0, RES_IDLE},
            '{CHR_LF,    1'b0, 1'b0, RES_IDLE},
            '{8'h58,     1'b0, 1'b0, RES_IDLE},     // partial name, then CR inside it
            '{CHR_CR,    1'b0, 1'b0, RES_IDLE},
            '{CHR_LF,    1'b0, 1'b1, '{STATUS_DONE, KIND_FRAMING, CHR_LF, 1'b0, 32'd0, 1'b0}},
            '{8'hFF,     1'b1, 1'b1, RES_IDLE}
        };
        foreach (rows[k]) send_byte(rows[k].data, rows[k].restart, rows[k].pinned, rows[k].want);
        drain_results();

        clean  = 1'b1;
        paused = 1'b0;
        while (sent < ITEM_TARGET) begin
            // restart after anything that may leave the parser mid-message
            if (!clean || $urandom_range(0, 9) == 0)
                send_byte(8'($urandom), 1'b1, 1'b0, RES_IDLE);
            build_response(clean);
            foreach (resp_bytes[k])
                send_byte(resp_bytes[k].data, resp_bytes[k].restart, 1'b0, RES_IDLE);
            if (!paused && sent >= ITEM_TARGET / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tag_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
